[rtl/idll_pkg.sv]
// Shared types and constants for the indexed doubly linked list core.
package idll_pkg;

	localparam int NODE_W      = 10;
	localparam int NODES_DEF   = 1024;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [1:0] {
		OP_INS_LEFT  = 2'd0,
		OP_INS_RIGHT = 2'd1,
		OP_DELETE    = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_READ,
		BK_EVAL,
		BK_FIN
	} back_state_t;

	// classified request as queued between front and back
	typedef struct packed {
		op_t   op;
		node_t node;
		node_t anchor;
		logic  node_ok;
		logic  anchor_ok;
	} req_t;

	typedef struct packed {
		status_t status;
		node_t   left;
		node_t   right;
		logic    in_list;
	} result_t;

endpackage

[rtl/idll_front.sv]
// Front end: accepts requests, range-checks node numbers, queues them for the back end.
module idll_front #(
	parameter int NODES = idll_pkg::NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  idll_pkg::op_t      operation,
	input  idll_pkg::node_t    node,
	input  idll_pkg::node_t    anchor,
	output logic               q_valid,
	output idll_pkg::req_t     q_req,
	input  logic               q_pop
);
	import idll_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	req_t          slot_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	req_t          new_req;

	assign in_stall = (cnt_q == CW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_req    = slot_q[rd_ptr_q];

	always_comb begin
		new_req.op        = operation;
		new_req.node      = node;
		new_req.anchor    = anchor;
		new_req.node_ok   = (32'(node) < NODES);
		new_req.anchor_ok = (32'(anchor) < NODES);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/idll_back.sv]
// Back end: link and membership memories, operation sequencer, result register.
module idll_back #(
	parameter int NODES = idll_pkg::NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  idll_pkg::req_t    q_req,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output idll_pkg::result_t out_res
);
	import idll_pkg::*;

	localparam int AW = $clog2(NODES);

	// link tables and membership, one write and two reads per cycle
	node_t left_mem   [NODES];
	node_t right_mem  [NODES];
	logic  member_mem [NODES];

	back_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	req_t          cur_q;

	node_t lx_q, rx_q, lp_q, rp_q;
	logic  mx_q, mp_q;

	logic    wr2_q;
	node_t   link_l_q, link_r_q;
	result_t res_q;
	result_t out_res_q;
	logic    out_valid_q;

	logic    lw_en, rw_en, mw_en;
	logic [AW-1:0] lw_addr, rw_addr, mw_addr;
	node_t   lw_data, rw_data;
	logic    mw_data;

	logic    x_present, p_present, ins_ok, del_ok;
	node_t   link_l, link_r;
	result_t res_d;
	logic    slot_free, clr_last;

	assign slot_free = !out_valid_q || !out_stall;
	assign clr_last  = (clr_q == AW'(NODES - 1));
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// decision for the item whose reads just returned
	always_comb begin
		x_present = cur_q.node_ok && mx_q;
		p_present = cur_q.anchor_ok && mp_q;
		ins_ok    = 1'b0;
		del_ok    = 1'b0;
		link_l    = cur_q.anchor;
		link_r    = rp_q;
		if (cur_q.op == OP_INS_LEFT) begin
			link_l = lp_q;
			link_r = cur_q.anchor;
		end
		res_d.status  = ST_DONE;
		res_d.left    = x_present ? lx_q : '0;
		res_d.right   = x_present ? rx_q : '0;
		res_d.in_list = x_present;
		unique case (cur_q.op) inside
			OP_INS_LEFT, OP_INS_RIGHT: begin
				ins_ok = cur_q.node_ok && (cur_q.node != '0) && !x_present && p_present;
				if (ins_ok) begin
					res_d.left    = link_l;
					res_d.right   = link_r;
					res_d.in_list = 1'b1;
				end else begin
					res_d.status = ST_REFUSED;
				end
			end
			OP_DELETE: begin
				del_ok = x_present && (cur_q.node != '0);
				if (del_ok) begin
					res_d.left    = '0;
					res_d.right   = '0;
					res_d.in_list = 1'b0;
				end else begin
					res_d.status = ST_ABSENT;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_last) state_d = BK_READ;
			BK_READ:  if (q_valid) state_d = BK_EVAL;
			BK_EVAL:  state_d = BK_FIN;
			BK_FIN:   if (slot_free) state_d = BK_READ;
			default:  state_d = BK_CLEAR;
		endcase
	end

	// memory controls
	always_comb begin
		q_pop   = 1'b0;
		lw_en   = 1'b0;
		rw_en   = 1'b0;
		mw_en   = 1'b0;
		lw_addr = AW'(cur_q.node);
		rw_addr = AW'(cur_q.node);
		mw_addr = AW'(cur_q.node);
		lw_data = '0;
		rw_data = '0;
		mw_data = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				// sentinel and node 1 form the initial list
				lw_en   = 1'b1;
				rw_en   = 1'b1;
				mw_en   = 1'b1;
				lw_addr = clr_q;
				rw_addr = clr_q;
				mw_addr = clr_q;
				lw_data = (clr_q == '0) ? NODE_W'(1) : '0;
				rw_data = (clr_q == '0) ? NODE_W'(1) : '0;
				mw_data = (clr_q < AW'(2));
			end
			BK_READ: begin
				q_pop = q_valid;
			end
			BK_EVAL: begin
				if (ins_ok) begin
					lw_en   = 1'b1;
					rw_en   = 1'b1;
					mw_en   = 1'b1;
					lw_data = link_l;
					rw_data = link_r;
					mw_data = 1'b1;
				end else if (del_ok) begin
					// unlink; the node's own links are never read while absent
					lw_en   = 1'b1;
					rw_en   = 1'b1;
					mw_en   = 1'b1;
					lw_addr = AW'(rx_q);
					lw_data = lx_q;
					rw_addr = AW'(lx_q);
					rw_data = rx_q;
					mw_data = 1'b0;
				end
			end
			BK_FIN: begin
				// repeats while the result waits; same address and data each time
				if (wr2_q) begin
					lw_en   = 1'b1;
					rw_en   = 1'b1;
					lw_addr = AW'(link_r_q);
					lw_data = cur_q.node;
					rw_addr = AW'(link_l_q);
					rw_data = cur_q.node;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			left_mem[lw_addr] <= lw_data;
		end
		if (rw_en) begin
			right_mem[rw_addr] <= rw_data;
		end
		if (mw_en) begin
			member_mem[mw_addr] <= mw_data;
		end
		if (q_pop) begin
			lx_q <= left_mem[AW'(q_req.node)];
			rx_q <= right_mem[AW'(q_req.node)];
			mx_q <= member_mem[AW'(q_req.node)];
			lp_q <= left_mem[AW'(q_req.anchor)];
			rp_q <= right_mem[AW'(q_req.anchor)];
			mp_q <= member_mem[AW'(q_req.anchor)];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (state_q == BK_EVAL) begin
			link_l_q <= link_l;
			link_r_q <= link_r;
			res_q    <= res_d;
		end
		if (state_q == BK_FIN && slot_free) begin
			out_res_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			wr2_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == BK_EVAL) begin
				wr2_q <= ins_ok;
			end
			if (state_q == BK_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/indexed_doubly_linked_list_core.sv]
// Top level of the indexed doubly linked list core.
//
// Keeps a list of node numbers (node 0 is the head sentinel) in link memories.
// Input channel: in_valid/in_stall with operation, node, anchor; one request
// is taken at each edge where in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with status, left_neighbor,
// right_neighbor, in_list; exactly one result per request, in order.
// A request passes through the queue, the registered memory read, the
// registered result and the output register before out_valid rises. The back
// end takes one request at a time through its read, evaluate and finish states,
// as an insert makes two writes into each link memory (one write port each).
// A 2-entry queue sits between front and back end, and a result register
// holds the finished result, so requests keep flowing while out_stall is
// high until the queue fills; then in_stall rises.
// After reset a clearing pass runs over all NODES entries, building the list that
// holds only node 1. Requests queue up meanwhile but are not processed.
module indexed_doubly_linked_list_core #(
	parameter int NODES = idll_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [idll_pkg::NODE_W-1:0] node,
	input  logic [idll_pkg::NODE_W-1:0] anchor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [idll_pkg::NODE_W-1:0] left_neighbor,
	output logic [idll_pkg::NODE_W-1:0] right_neighbor,
	output logic                        in_list
);
	import idll_pkg::*;

	logic    q_valid;
	logic    q_pop;
	req_t    q_req;
	result_t out_res;

	idll_front #(
		.NODES(NODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(op_t'(operation)),
		.node     (node),
		.anchor   (anchor),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	idll_back #(
		.NODES(NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign status         = out_res.status;
	assign left_neighbor  = out_res.left;
	assign right_neighbor = out_res.right;
	assign in_list        = out_res.in_list;

`ifndef SYNTHESIS
	a_pop_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_absent_has_no_links: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_list |-> left_neighbor == '0 && right_neighbor == '0)
		else $error("absent node reported with links");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable({status, left_neighbor, right_neighbor, in_list}))
		else $error("stalled result changed or dropped");
`endif

endmodule
